### src/mgtb_pkg.sv
// shared types, codes and defaults of the microbial ga tournament breed unit
package mgtb_pkg;

    // default sizes
    localparam int unsigned POP_SIZE_DEF   = 128;
    localparam int unsigned NUM_GENES_DEF  = 32;
    localparam int unsigned GENE_WIDTH_DEF = 16;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] CFG_REC_THR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUT_THR  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUT_STEP = 2'd2;

    // register reset values
    localparam logic [9:0]  REC_THR_RST  = 10'd500;
    localparam logic [9:0]  MUT_THR_RST  = 10'd100;
    localparam logic [14:0] MUT_STEP_RST = 15'd128;

    // command codes
    localparam logic [2:0] CMD_WR_GENE = 3'd0;
    localparam logic [2:0] CMD_WR_FIT  = 3'd1;
    localparam logic [2:0] CMD_RD_GENE = 3'd2;
    localparam logic [2:0] CMD_TOURN   = 3'd3;
    localparam logic [2:0] CMD_BREED   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAME     = 2'd1;
    localparam logic [1:0] ST_NO_TOURN = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // input word
    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         ind_a;
        logic [6:0]         ind_b;
        logic [4:0]         gene_index;
        logic signed [31:0] value;
        logic [9:0]         rec_draw;
        logic [9:0]         mut_draw;
        logic               mut_up;
    } item_t;

    // result word
    typedef struct packed {
        logic [6:0]         loser_index;
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } result_t;

    // decoded operation
    typedef enum logic [2:0] {
        OP_WR_GENE,
        OP_WR_FIT,
        OP_RD_GENE,
        OP_TOURN,
        OP_BREED,
        OP_NOP
    } op_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t                op;
        logic [6:0]         ind_a;
        logic [6:0]         ind_b;
        logic [4:0]         gene_index;
        logic signed [31:0] value;
        logic               sat;
        logic               same;
        logic               rec_hit;
        logic               mut_hit;
        logic               mut_up;
    } entry_t;

    // back sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

endpackage

### src/mgtb_front.sv
// front end: configuration registers, index folding, clamping and command decode
module mgtb_front #(
    parameter int unsigned POP_SIZE   = mgtb_pkg::POP_SIZE_DEF,
    parameter int unsigned NUM_GENES  = mgtb_pkg::NUM_GENES_DEF,
    parameter int unsigned GENE_WIDTH = mgtb_pkg::GENE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  mgtb_pkg::item_t                   item_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mgtb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mgtb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output mgtb_pkg::entry_t                  q_entry,
    output logic [14:0]                       mut_step
);

    localparam longint GENE_HI_L = (longint'(1) << (GENE_WIDTH - 1)) - 1;
    localparam logic signed [32:0] GENE_HI = 33'(GENE_HI_L);
    localparam logic signed [32:0] GENE_LO = 33'(-GENE_HI_L - 1);

    logic [9:0]  rec_thr_reg;
    logic [9:0]  mut_thr_reg;
    logic [14:0] mut_step_reg;

    logic [6:0] ind_fold [128];
    logic [4:0] gene_fold [32];

    logic signed [32:0] value_ext;
    logic signed [31:0] gene_clamped;
    logic               gene_sat;
    logic [6:0]         fa;
    logic [6:0]         fb;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;
    assign mut_step  = mut_step_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rec_thr_reg  <= mgtb_pkg::REC_THR_RST;
            mut_thr_reg  <= mgtb_pkg::MUT_THR_RST;
            mut_step_reg <= mgtb_pkg::MUT_STEP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mgtb_pkg::CFG_REC_THR:  rec_thr_reg  <= cfg_data[9:0];
                mgtb_pkg::CFG_MUT_THR:  mut_thr_reg  <= cfg_data[9:0];
                mgtb_pkg::CFG_MUT_STEP: mut_step_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // constant folding tables for out-of-range indices
    for (genvar i = 0; i < 128; i++) begin : g_ind_fold
        localparam int unsigned FOLDED = i % POP_SIZE;
        assign ind_fold[i] = 7'(FOLDED);
    end

    for (genvar j = 0; j < 32; j++) begin : g_gene_fold
        localparam int unsigned FOLDED = j % NUM_GENES;
        assign gene_fold[j] = 5'(FOLDED);
    end

    assign fa = ind_fold[item_word.ind_a];
    assign fb = ind_fold[item_word.ind_b];

    // clamp a written gene to the gene range
    assign value_ext = {item_word.value[31], item_word.value};

    always_comb begin
        gene_sat     = 1'b0;
        gene_clamped = item_word.value;
        if (value_ext > GENE_HI) begin
            gene_sat     = 1'b1;
            gene_clamped = 32'(GENE_HI);
        end else if (value_ext < GENE_LO) begin
            gene_sat     = 1'b1;
            gene_clamped = 32'(GENE_LO);
        end
    end

    // push into the queue whenever it has room
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // command decode and classification
    always_comb begin
        q_entry.ind_a      = fa;
        q_entry.ind_b      = fb;
        q_entry.gene_index = gene_fold[item_word.gene_index];
        q_entry.value      = item_word.value;
        q_entry.sat        = gene_sat;
        q_entry.same       = (fa == fb);
        q_entry.rec_hit    = item_word.rec_draw < rec_thr_reg;
        q_entry.mut_hit    = item_word.mut_draw < mut_thr_reg;
        q_entry.mut_up     = item_word.mut_up;
        unique case (item_word.cmd)
            mgtb_pkg::CMD_WR_GENE:
            begin
                q_entry.op    = mgtb_pkg::OP_WR_GENE;
                q_entry.value = gene_clamped;
            end
            mgtb_pkg::CMD_WR_FIT:  q_entry.op = mgtb_pkg::OP_WR_FIT;
            mgtb_pkg::CMD_RD_GENE: q_entry.op = mgtb_pkg::OP_RD_GENE;
            mgtb_pkg::CMD_TOURN:   q_entry.op = mgtb_pkg::OP_TOURN;
            mgtb_pkg::CMD_BREED:   q_entry.op = mgtb_pkg::OP_BREED;
            default:               q_entry.op = mgtb_pkg::OP_NOP;
        endcase
    end

endmodule

### src/mgtb_queue.sv
// small fifo of classified words between front and back
module mgtb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mgtb_pkg::entry_t entry_in,
    output logic             full,
    input  logic             pop,
    output mgtb_pkg::entry_t entry_out,
    output logic             empty
);

    localparam int unsigned PTRW = $clog2(mgtb_pkg::QUEUE_DEPTH);

    mgtb_pkg::entry_t slots [mgtb_pkg::QUEUE_DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_next;
    logic [PTRW:0]    count_reg;
    logic [PTRW:0]    count_next;

    assign full      = (count_reg == (PTRW+1)'(mgtb_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign entry_out = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk) begin
        if (push) begin
            slots[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

### src/mgtb_back.sv
// back end: gene and fitness memories, tournament latch, breed datapath, result register
module mgtb_back #(
    parameter int unsigned POP_SIZE   = mgtb_pkg::POP_SIZE_DEF,
    parameter int unsigned NUM_GENES  = mgtb_pkg::NUM_GENES_DEF,
    parameter int unsigned GENE_WIDTH = mgtb_pkg::GENE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  mgtb_pkg::entry_t  q_entry,
    input  logic [14:0]       mut_step,
    output logic              result_valid,
    input  logic              result_stall,
    output mgtb_pkg::result_t result_word
);

    localparam int unsigned GENE_DEPTH = POP_SIZE * NUM_GENES;
    localparam int unsigned GADW       = $clog2(GENE_DEPTH);
    localparam int unsigned FADW       = $clog2(POP_SIZE);
    localparam int unsigned SUMW       = (GENE_WIDTH > 16 ? GENE_WIDTH : 16) + 2;
    localparam longint GENE_HI_L = (longint'(1) << (GENE_WIDTH - 1)) - 1;
    localparam logic signed [SUMW-1:0] BR_HI = SUMW'(GENE_HI_L);
    localparam logic signed [SUMW-1:0] BR_LO = SUMW'(-GENE_HI_L - 1);

    logic signed [GENE_WIDTH-1:0] gene_mem [GENE_DEPTH];
    logic signed [31:0]           fit_mem [POP_SIZE];

    mgtb_pkg::bk_state_t state_reg;
    mgtb_pkg::bk_state_t state_next;

    mgtb_pkg::entry_t cur_reg;
    logic [GADW-1:0]  gene_waddr_reg;

    logic signed [GENE_WIDTH-1:0] gene_rd_a_reg;
    logic signed [GENE_WIDTH-1:0] gene_rd_b_reg;
    logic signed [31:0]           fit_rd_a_reg;
    logic signed [31:0]           fit_rd_b_reg;

    logic [6:0] winner_reg;
    logic [6:0] winner_next;
    logic [6:0] loser_reg;
    logic [6:0] loser_next;
    logic       tvalid_reg;
    logic       tvalid_next;

    logic              res_valid_reg;
    mgtb_pkg::result_t res_word_reg;
    mgtb_pkg::result_t res_word_next;

    logic fire;

    logic [GADW-1:0] gene_ra;
    logic [GADW-1:0] gene_rb;
    logic [FADW-1:0] fit_ra;
    logic [FADW-1:0] fit_rb;

    logic                         gene_we;
    logic signed [GENE_WIDTH-1:0] gene_wdata;
    logic                         fit_we;

    logic signed [GENE_WIDTH-1:0] breed_base;
    logic signed [SUMW-1:0]       base_ext;
    logic signed [SUMW-1:0]       step_ext;
    logic signed [SUMW-1:0]       breed_sum;
    logic signed [GENE_WIDTH-1:0] breed_gene;
    logic                         breed_sat;

    // read addresses for the word at the queue head
    always_comb begin
        if (q_entry.op == mgtb_pkg::OP_BREED) begin
            gene_ra = GADW'(loser_reg) * GADW'(NUM_GENES) + GADW'(q_entry.gene_index);
        end else begin
            gene_ra = GADW'(q_entry.ind_a) * GADW'(NUM_GENES) + GADW'(q_entry.gene_index);
        end
        gene_rb = GADW'(winner_reg) * GADW'(NUM_GENES) + GADW'(q_entry.gene_index);
        fit_ra  = FADW'(q_entry.ind_a);
        fit_rb  = FADW'(q_entry.ind_b);
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mgtb_pkg::BK_IDLE:
            begin
                if (!q_empty) begin
                    state_next = mgtb_pkg::BK_EXEC;
                end
            end
            mgtb_pkg::BK_EXEC:
            begin
                if (!res_valid_reg || !result_stall) begin
                    state_next = mgtb_pkg::BK_IDLE;
                end
            end
            default: state_next = mgtb_pkg::BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_pop = 1'b0;
        fire  = 1'b0;
        unique case (state_reg)
            mgtb_pkg::BK_IDLE: q_pop = !q_empty;
            mgtb_pkg::BK_EXEC: fire  = !res_valid_reg || !result_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= mgtb_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // latch the popped word and its gene slot
    always_ff @(posedge clk) begin
        if (q_pop) begin
            cur_reg        <= q_entry;
            gene_waddr_reg <= gene_ra;
        end
    end

    // gene memory, two read ports and one write port
    always_ff @(posedge clk) begin
        if (gene_we) begin
            gene_mem[gene_waddr_reg] <= gene_wdata;
        end
        if (q_pop) begin
            gene_rd_a_reg <= gene_mem[gene_ra];
            gene_rd_b_reg <= gene_mem[gene_rb];
        end
    end

    // fitness memory, two read ports and one write port
    always_ff @(posedge clk) begin
        if (fit_we) begin
            fit_mem[FADW'(cur_reg.ind_a)] <= cur_reg.value;
        end
        if (q_pop) begin
            fit_rd_a_reg <= fit_mem[fit_ra];
            fit_rd_b_reg <= fit_mem[fit_rb];
        end
    end

    // breed datapath: pick parent gene, then mutate with saturation
    assign breed_base = cur_reg.rec_hit ? gene_rd_b_reg : gene_rd_a_reg;
    assign base_ext   = SUMW'(breed_base);
    assign step_ext   = SUMW'(mut_step);
    assign breed_sum  = cur_reg.mut_up ? base_ext + step_ext : base_ext - step_ext;

    always_comb begin
        breed_sat  = 1'b0;
        breed_gene = breed_base;
        if (cur_reg.mut_hit) begin
            if (breed_sum > BR_HI) begin
                breed_sat  = 1'b1;
                breed_gene = GENE_WIDTH'(BR_HI);
            end else if (breed_sum < BR_LO) begin
                breed_sat  = 1'b1;
                breed_gene = GENE_WIDTH'(BR_LO);
            end else begin
                breed_gene = breed_sum[GENE_WIDTH-1:0];
            end
        end
    end

    // execute the current word
    always_comb begin
        gene_we     = 1'b0;
        fit_we      = 1'b0;
        gene_wdata  = cur_reg.value[GENE_WIDTH-1:0];
        winner_next = winner_reg;
        loser_next  = loser_reg;
        tvalid_next = tvalid_reg;
        res_word_next.read_value = '0;
        res_word_next.status     = mgtb_pkg::ST_OK;
        case (cur_reg.op)
            mgtb_pkg::OP_WR_GENE:
            begin
                gene_we = fire;
                res_word_next.read_value = 32'(gene_wdata);
                res_word_next.status     = cur_reg.sat ? mgtb_pkg::ST_SAT : mgtb_pkg::ST_OK;
            end
            mgtb_pkg::OP_WR_FIT:
            begin
                fit_we = fire;
                res_word_next.read_value = cur_reg.value;
            end
            mgtb_pkg::OP_RD_GENE:
            begin
                res_word_next.read_value = 32'(gene_rd_a_reg);
            end
            mgtb_pkg::OP_TOURN:
            begin
                if (cur_reg.same) begin
                    res_word_next.status = mgtb_pkg::ST_SAME;
                end else begin
                    tvalid_next = 1'b1;
                    if (fit_rd_a_reg < fit_rd_b_reg) begin
                        winner_next = cur_reg.ind_a;
                        loser_next  = cur_reg.ind_b;
                    end else begin
                        winner_next = cur_reg.ind_b;
                        loser_next  = cur_reg.ind_a;
                    end
                end
            end
            mgtb_pkg::OP_BREED:
            begin
                if (!tvalid_reg) begin
                    res_word_next.status = mgtb_pkg::ST_NO_TOURN;
                end else begin
                    gene_we    = fire;
                    gene_wdata = breed_gene;
                    res_word_next.read_value = 32'(breed_gene);
                    res_word_next.status     = breed_sat ? mgtb_pkg::ST_SAT : mgtb_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        res_word_next.loser_index = loser_next;
    end

    // tournament latch
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            winner_reg <= '0;
            loser_reg  <= '0;
            tvalid_reg <= 1'b0;
        end else if (fire) begin
            winner_reg <= winner_next;
            loser_reg  <= loser_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            res_word_reg <= res_word_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;

endmodule

### src/microbial_ga_tournament_breed_unit.sv
// top level of the microbial ga tournament breed unit
//
//   channel   signals                             direction   handshake
//   item      item_valid item_stall item_word     in          valid & !stall
//   result    result_valid result_stall result_word  out      valid & !stall
//   cfg       cfg_valid cfg_ready cfg_index cfg_data  in       valid & ready
//
// the back sequencer's idle step pops each word and reads the gene and fitness
// memories, the execute step runs and writes back; the front keeps taking words
// into a two-entry queue meanwhile. a stalled result holds the sequencer in its
// execute step. reset clears the queue, the sequencer, the tournament latch and
// restores the register defaults; memories hold nothing defined until written.
module microbial_ga_tournament_breed_unit #(
    parameter int unsigned POP_SIZE   = mgtb_pkg::POP_SIZE_DEF,
    parameter int unsigned NUM_GENES  = mgtb_pkg::NUM_GENES_DEF,
    parameter int unsigned GENE_WIDTH = mgtb_pkg::GENE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mgtb_pkg::item_t                  item_word,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mgtb_pkg::result_t                result_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mgtb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mgtb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    mgtb_pkg::entry_t q_in;
    mgtb_pkg::entry_t q_out;
    logic [14:0]      mut_step;

    // accept and classify
    mgtb_front #(
        .POP_SIZE   (POP_SIZE),
        .NUM_GENES  (NUM_GENES),
        .GENE_WIDTH (GENE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_word  (item_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in),
        .mut_step   (mut_step)
    );

    // decoupling queue
    mgtb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .entry_out (q_out),
        .empty     (q_empty)
    );

    // execute
    mgtb_back #(
        .POP_SIZE   (POP_SIZE),
        .NUM_GENES  (NUM_GENES),
        .GENE_WIDTH (GENE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_entry      (q_out),
        .mut_step     (mut_step),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule
